### rtl/beacon_tracking_table_core_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the beacon tracking table
// ---------------------------------------------------------------------------
`ifndef BEACON_TRACKING_TABLE_CORE_MACROS_SVH
`define BEACON_TRACKING_TABLE_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define BTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define BTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/btt_pkg.sv
// ---------------------------------------------------------------------------
// btt_pkg
// shared types and constants of the beacon tracking table
// ---------------------------------------------------------------------------
package btt_pkg;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_EXPIRE  = 2'd1;
  localparam logic [1:0] CMD_REPORT  = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [1:0] REG_SHOW_ALL = 2'd0;
  localparam logic [1:0] REG_ALPHA    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam int unsigned AlphaReset   = 77;
  localparam int unsigned TimeoutReset = 120000;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic rd;        // read entry at index
    logic wr_upd;    // write blended entry at index
    logic wr_new;    // write new entry at index
    logic wr_move;   // write moved entry (last) at index
    logic mul;       // register products
  } btt_cmd_t;

endpackage

### rtl/beacon_tracking_table_core.sv
// an observe walks the entries until a hit or the fill count, an expire walks them all
// a report gives one result per entry and waits on a busy output; one item in work at a time
// the sequencer walks the entry table one entry at a time
// reset: table empty, show_all 0, alpha 77, timeout 120000 ms; entry contents
// are undefined until written and are never read beyond the fill count
// ---------------------------------------------------------------------------
// beacon_tracking_table_core
// tracked beacon table with ema smoothing, expiry and report
// ---------------------------------------------------------------------------
`include "beacon_tracking_table_core_macros.svh"

module beacon_tracking_table_core #(
  parameter int MAX_BEACONS        = 20,
  parameter int STRENGTH_FRAC_BITS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0] beacon_id[33:2] address_id[65:34] rssi[73:66] battery[81:74]
  // kind[89:82] now_ms[121:90]
  input  logic [127:0] s_axis_tdata,
  // has_data
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_id[31:0] out_rssi[39:32] out_battery[47:40] out_kind[55:48]
  // out_seen[87:56] entry_valid[88]
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int IdxW = (MAX_BEACONS > 1) ? $clog2(MAX_BEACONS) : 1;
  localparam int CntW = $clog2(MAX_BEACONS + 1);

  // config registers
  logic        show_all_q;
  logic [8:0]  alpha_q;
  logic [31:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_all_q <= 1'b0;
      alpha_q    <= 9'(btt_pkg::AlphaReset);
      timeout_q  <= btt_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btt_pkg::REG_SHOW_ALL: show_all_q <= cfg_data_i[0];
        btt_pkg::REG_ALPHA:    alpha_q    <= cfg_data_i[8:0];
        btt_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  btt_pkg::btt_cmd_t cmd;
  logic [IdxW-1:0]   idx, last_idx;
  logic [CntW-1:0]   count;
  logic              use_addr, hit, stale;
  logic              res_valid, res_entry, res_last, res_free;
  logic [31:0]       rd_id, rd_seen;
  logic signed [7:0] rd_rssi;
  logic [7:0]        rd_batt, rd_kind;

  btt_ctrl #(.MaxBeacons(MAX_BEACONS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .command_i  (s_axis_tdata[1:0]),
    .has_data_i (s_axis_tuser),
    .show_all_i (show_all_q),
    .use_addr_o (use_addr),
    .hit_i      (hit),
    .stale_i    (stale),
    .cmd_o      (cmd),
    .idx_o      (idx),
    .last_idx_o (last_idx),
    .count_o    (count),
    .res_valid_o(res_valid),
    .res_entry_o(res_entry),
    .res_last_o (res_last),
    .res_free_i (res_free)
  );

  btt_datapath #(.MaxBeacons(MAX_BEACONS), .FracBits(STRENGTH_FRAC_BITS)) u_dp (
    .clk_i,
    .cmd_i       (cmd),
    .idx_i       (idx),
    .last_idx_i  (last_idx),
    .use_addr_i  (use_addr),
    .beacon_id_i (s_axis_tdata[33:2]),
    .address_id_i(s_axis_tdata[65:34]),
    .rssi_i      (s_axis_tdata[73:66]),
    .battery_i   (s_axis_tdata[81:74]),
    .kind_i      (s_axis_tdata[89:82]),
    .now_ms_i    (s_axis_tdata[121:90]),
    .alpha_i     (alpha_q),
    .timeout_i   (timeout_q),
    .hit_o       (hit),
    .stale_o     (stale),
    .rd_id_o     (rd_id),
    .rd_rssi_o   (rd_rssi),
    .rd_batt_o   (rd_batt),
    .rd_kind_o   (rd_kind),
    .rd_seen_o   (rd_seen)
  );

  // output register; free when empty or being taken
  logic        out_valid_q;
  logic [95:0] out_data_q;
  logic        out_last_q;

  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      // empty table gives an all-zero item
      out_data_q <= res_entry
                  ? {7'd0, 1'b1, rd_seen, rd_kind, rd_batt, rd_rssi, rd_id} : '0;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // fill count never exceeds the table size
  `BTT_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count <= CntW'(MAX_BEACONS))
  // no input taken while a result waits to be produced
  `BTT_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, res_valid, !s_axis_tready)
  // a stalled result stays put
  `BTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

### rtl/btt_datapath.sv
// ---------------------------------------------------------------------------
// btt_datapath
// entry memory, item registers, ema blend and age compare
// ---------------------------------------------------------------------------
module btt_datapath #(
  parameter int MaxBeacons = 20,
  parameter int FracBits   = 8,
  localparam int IdxW = (MaxBeacons > 1) ? $clog2(MaxBeacons) : 1,
  localparam int StrW = 8 + FracBits
) (
  input  logic                 clk_i,
  input  btt_pkg::btt_cmd_t    cmd_i,
  input  logic [IdxW-1:0]      idx_i,
  input  logic [IdxW-1:0]      last_idx_i,
  input  logic                 use_addr_i,
  input  logic [31:0]          beacon_id_i,
  input  logic [31:0]          address_id_i,
  input  logic signed [7:0]    rssi_i,
  input  logic [7:0]           battery_i,
  input  logic [7:0]           kind_i,
  input  logic [31:0]          now_ms_i,
  input  logic [8:0]           alpha_i,
  input  logic [31:0]          timeout_i,
  output logic                 hit_o,
  output logic                 stale_o,
  output logic [31:0]          rd_id_o,
  output logic signed [7:0]    rd_rssi_o,
  output logic [7:0]           rd_batt_o,
  output logic [7:0]           rd_kind_o,
  output logic [31:0]          rd_seen_o
);

  localparam int AccW = StrW + 10;

  logic [31:0]           mem_id   [MaxBeacons];
  logic signed [StrW-1:0] mem_str [MaxBeacons];
  logic [7:0]            mem_batt [MaxBeacons];
  logic [7:0]            mem_kind [MaxBeacons];
  logic [31:0]           mem_time [MaxBeacons];

  logic [31:0]           id_q, now_q;
  logic signed [7:0]     rssi_q;
  logic [7:0]            batt_q, kind_q;
  logic signed [StrW-1:0] str_q;
  logic signed [AccW-1:0] pa_q, pb_q;
  logic [8:0]            a_sat;
  logic signed [AccW-1:0] acc;
  logic signed [StrW-1:0] sample, blended, rd_str;
  logic [31:0]           age;

  assign a_sat   = alpha_i[8] ? 9'd256 : alpha_i;
  assign sample  = StrW'(rssi_q) <<< FracBits;
  assign acc     = pa_q + pb_q + AccW'(128);
  assign blended = StrW'(acc >>> 8);
  assign age     = now_q - rd_seen_o;
  assign stale_o = age > timeout_i;
  assign hit_o   = rd_id_o == id_q;
  assign rd_str  = str_q;
  assign rd_rssi_o = rd_str[StrW-1]
                   ? 8'(-((-rd_str) >>> FracBits)) : 8'(rd_str >>> FracBits);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= use_addr_i ? address_id_i : beacon_id_i;
      batt_q <= use_addr_i ? 8'd0 : battery_i;
      kind_q <= use_addr_i ? 8'd0 : kind_i;
      rssi_q <= rssi_i;
      now_q  <= now_ms_i;
    end
    if (cmd_i.rd) begin
      rd_id_o   <= mem_id[idx_i];
      str_q     <= mem_str[idx_i];
      rd_batt_o <= mem_batt[idx_i];
      rd_kind_o <= mem_kind[idx_i];
      rd_seen_o <= mem_time[idx_i];
    end
    if (cmd_i.mul) begin
      pa_q <= AccW'($signed({1'b0, a_sat})) * AccW'(sample);
      pb_q <= AccW'($signed(10'd256 - {1'b0, a_sat})) * AccW'(str_q);
    end
    if (cmd_i.wr_upd || cmd_i.wr_new) begin
      mem_id[idx_i]   <= id_q;
      mem_str[idx_i]  <= cmd_i.wr_new ? sample : blended;
      mem_batt[idx_i] <= batt_q;
      mem_kind[idx_i] <= kind_q;
      mem_time[idx_i] <= now_q;
    end
    if (cmd_i.wr_move) begin
      mem_id[idx_i]   <= mem_id[last_idx_i];
      mem_str[idx_i]  <= mem_str[last_idx_i];
      mem_batt[idx_i] <= mem_batt[last_idx_i];
      mem_kind[idx_i] <= mem_kind[last_idx_i];
      mem_time[idx_i] <= mem_time[last_idx_i];
    end
  end

endmodule

### rtl/btt_ctrl.sv
// ---------------------------------------------------------------------------
// btt_ctrl
// sequencer for lookup, expiry and report walks
// ---------------------------------------------------------------------------
module btt_ctrl #(
  parameter int MaxBeacons = 20,
  localparam int IdxW = (MaxBeacons > 1) ? $clog2(MaxBeacons) : 1,
  localparam int CntW = $clog2(MaxBeacons + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic              has_data_i,
  input  logic              show_all_i,
  output logic              use_addr_o,
  input  logic              hit_i,
  input  logic              stale_i,
  output btt_pkg::btt_cmd_t cmd_o,
  output logic [IdxW-1:0]   idx_o,
  output logic [IdxW-1:0]   last_idx_o,
  output logic [CntW-1:0]   count_o,
  output logic              res_valid_o,
  output logic              res_entry_o,
  output logic              res_last_o,
  input  logic              res_free_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_LREAD, S_LCHK, S_MUL, S_EREAD, S_ECHK, S_RREAD, S_RPUT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d, cnt_q, cnt_d;

  assign use_addr_o = !has_data_i;
  assign in_ready_o = state_q == S_IDLE;
  assign idx_o      = idx_q[IdxW-1:0];
  assign last_idx_o = IdxW'(cnt_q - CntW'(1));
  assign count_o    = cnt_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    res_valid_o = 1'b0;
    res_entry_o = 1'b0;
    res_last_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (command_i)
            btt_pkg::CMD_OBSERVE:
              if (has_data_i || show_all_i) state_d = S_LREAD;
            btt_pkg::CMD_EXPIRE: state_d = S_EREAD;
            btt_pkg::CMD_REPORT: state_d = S_RREAD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LREAD: begin
        if (idx_q == cnt_q) begin
          if (cnt_q != CntW'(MaxBeacons)) begin
            cmd_o.wr_new = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
          state_d = S_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_LCHK;
        end
      end
      S_LCHK: begin
        if (hit_i) begin
          cmd_o.mul = 1'b1;
          state_d   = S_MUL;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_LREAD;
        end
      end
      S_MUL: begin
        cmd_o.wr_upd = 1'b1;
        state_d      = S_IDLE;
      end
      S_EREAD: begin
        if (idx_q == cnt_q) state_d = S_IDLE;
        else begin
          cmd_o.rd = 1'b1;
          state_d  = S_ECHK;
        end
      end
      S_ECHK: begin
        if (stale_i) begin
          cmd_o.wr_move = 1'b1;
          cnt_d = cnt_q - CntW'(1);
        end else idx_d = idx_q + CntW'(1);
        state_d = S_EREAD;
      end
      S_RREAD: begin
        if (cnt_q != '0) cmd_o.rd = 1'b1;
        state_d = S_RPUT;
      end
      S_RPUT: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          res_entry_o = cnt_q != '0;
          res_last_o  = (cnt_q == '0) || (idx_q == cnt_q - CntW'(1));
          if (res_last_o) state_d = S_IDLE;
          else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_RREAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// beacon tracking table testbench
// drives observe, expire and report items into the table over the stream
// bus, keeps a shadow table in the bench and compares every report item
// field by field against it; random idling on both sides
// ---------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 20;
  localparam int unsigned RandItems  = 400;
  localparam int unsigned StallLimit = 20000;
  // drain wait after the last report, long enough for a full table walk
  localparam int unsigned DrainCycles = 100;

  // one report item as seen on the master side
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  rssi;
    logic [7:0]  batt;
    logic [7:0]  kind;
    logic [31:0] seen;
    logic        valid;
    logic        last;
  } report_t;

  // one input item, the directed table holds these
  typedef struct {
    logic [1:0]  cmd;
    logic        has_data;
    logic [31:0] bid;
    logic [31:0] aid;
    logic [7:0]  rssi;
    logic [7:0]  batt;
    logic [7:0]  kind;
    logic [31:0] now;
  } sighting_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tlast;

  beacon_tracking_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // shadow table
  logic [31:0]        tbl_id   [NumEntries];
  logic signed [31:0] tbl_str  [NumEntries];
  logic [7:0]         tbl_batt [NumEntries];
  logic [7:0]         tbl_kind [NumEntries];
  logic [31:0]        tbl_seen [NumEntries];
  int                 tbl_fill;
  logic               shw_all;
  logic [8:0]         shw_alpha;
  logic [31:0]        shw_timeout;

  report_t     pending_reports[$];
  int          err_cnt;
  int unsigned idle_cycles;
  bit          no_stall;     // long stretch with no idling on either side
  bit          done_flag;

  // ema in q8.8, round half up, alpha saturates at 256
  function automatic logic signed [31:0] ema_blend(logic signed [31:0] prev,
                                                   logic signed [31:0] smp);
    longint a;
    longint acc;
    a = (shw_alpha > 9'd256) ? 256 : longint'(shw_alpha);
    acc = a * longint'(smp) + (256 - a) * longint'(prev) + 128;
    return 32'(acc >>> 8);
  endfunction

  // integer part truncated toward zero
  function automatic logic [7:0] trunc_dbm(logic signed [31:0] q);
    logic signed [31:0] v;
    v = (q >= 0) ? (q >>> 8) : -((-q) >>> 8);
    return v[7:0];
  endfunction

  // advance the shadow table by one accepted item, queue report items
  function automatic void track_sighting(sighting_t s);
    logic [31:0] ident;
    logic [7:0]  b;
    logic [7:0]  k;
    logic signed [31:0] smp;
    int i;
    int hit;
    report_t r;
    case (s.cmd)
      btt_pkg::CMD_OBSERVE: begin
        if (s.has_data) begin
          ident = s.bid; b = s.batt; k = s.kind;
        end else if (shw_all) begin
          ident = s.aid; b = '0; k = '0;
        end else begin
          return;
        end
        smp = 32'($signed(s.rssi)) * 256;
        hit = -1;
        for (i = 0; i < tbl_fill; i++)
          if (hit < 0 && tbl_id[i] == ident) hit = i;
        if (hit >= 0) begin
          tbl_str[hit] = ema_blend(tbl_str[hit], smp);
          tbl_batt[hit] = b; tbl_kind[hit] = k; tbl_seen[hit] = s.now;
        end else if (tbl_fill < NumEntries) begin
          tbl_id[tbl_fill] = ident; tbl_str[tbl_fill] = smp;
          tbl_batt[tbl_fill] = b; tbl_kind[tbl_fill] = k;
          tbl_seen[tbl_fill] = s.now;
          tbl_fill++;
        end
      end
      btt_pkg::CMD_EXPIRE: begin
        // stale entry is replaced by the last one, then rechecked
        i = 0;
        while (i < tbl_fill) begin
          if (32'(s.now - tbl_seen[i]) > shw_timeout) begin
            tbl_id[i] = tbl_id[tbl_fill-1]; tbl_str[i] = tbl_str[tbl_fill-1];
            tbl_batt[i] = tbl_batt[tbl_fill-1];
            tbl_kind[i] = tbl_kind[tbl_fill-1];
            tbl_seen[i] = tbl_seen[tbl_fill-1];
            tbl_fill--;
          end else begin
            i++;
          end
        end
      end
      btt_pkg::CMD_REPORT: begin
        if (tbl_fill == 0) begin
          r = '0; r.last = 1'b1;
          pending_reports.push_back(r);
        end
        for (i = 0; i < tbl_fill; i++) begin
          r.id = tbl_id[i]; r.rssi = trunc_dbm(tbl_str[i]);
          r.batt = tbl_batt[i]; r.kind = tbl_kind[i]; r.seen = tbl_seen[i];
          r.valid = 1'b1; r.last = (i == tbl_fill - 1);
          pending_reports.push_back(r);
        end
      end
      default: ;  // unused code is ignored
    endcase
  endfunction

  // one register write, with the enable dropped again before anything else is driven
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      btt_pkg::REG_SHOW_ALL: shw_all = val[0];
      btt_pkg::REG_ALPHA:    shw_alpha = val[8:0];
      default:               shw_timeout = val;
    endcase
    @(posedge clk_i);
  endtask

  // hand one item to the block, with random gaps before it
  task automatic send_sighting(sighting_t s);
    if (!no_stall && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (!no_stall && $urandom_range(99) < 18) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= s.has_data;
    s_axis_tdata <= {6'd0, s.now, s.kind, s.batt, s.rssi, s.aid, s.bid, s.cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_sighting(s);
  endtask

  // wait until all reports are back, then let the walk settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic sighting_t rand_sighting(logic [31:0] t);
    sighting_t s;
    int p;
    p = $urandom_range(99);
    s.cmd = (p < 70) ? btt_pkg::CMD_OBSERVE :
            (p < 82) ? btt_pkg::CMD_EXPIRE :
            (p < 97) ? btt_pkg::CMD_REPORT : btt_pkg::CMD_UNUSED;
    s.has_data = ($urandom_range(3) != 0);
    // small id pool so hits are common, sometimes any id
    s.bid = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(27));
    s.aid = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(27));
    s.rssi = 8'($urandom());
    s.batt = 8'($urandom());
    s.kind = 8'($urandom());
    s.now = t;
    return s;
  endfunction

  // master side: random backpressure and checking
  always @(posedge clk_i) begin
    report_t got;
    report_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[39:32], m_axis_tdata[47:40],
               m_axis_tdata[55:48], m_axis_tdata[87:56], m_axis_tdata[88],
               m_axis_tlast};
        if (pending_reports.size() == 0) begin
          $error("unexpected report item id %0h", got.id);
          err_cnt++;
        end else begin
          exp_r = pending_reports.pop_front();
          if (got.id !== exp_r.id) begin
            $error("out_id exp %0h got %0h", exp_r.id, got.id); err_cnt++;
          end
          if (got.rssi !== exp_r.rssi) begin
            $error("out_rssi exp %0d got %0d", $signed(exp_r.rssi),
                   $signed(got.rssi)); err_cnt++;
          end
          if (got.batt !== exp_r.batt) begin
            $error("out_battery exp %0d got %0d", exp_r.batt, got.batt); err_cnt++;
          end
          if (got.kind !== exp_r.kind) begin
            $error("out_kind exp %0d got %0d", exp_r.kind, got.kind); err_cnt++;
          end
          if (got.seen !== exp_r.seen) begin
            $error("out_seen exp %0h got %0h", exp_r.seen, got.seen); err_cnt++;
          end
          if (got.valid !== exp_r.valid) begin
            $error("entry_valid exp %0b got %0b", exp_r.valid, got.valid); err_cnt++;
          end
          if (got.last !== exp_r.last) begin
            $error("last exp %0b got %0b", exp_r.last, got.last); err_cnt++;
          end
        end
      end
      m_axis_tready <= no_stall || ($urandom_range(99) >= 18);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || done_flag || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // directed rows: hits, extremes, payload-less sightings, an unused command, a report
  sighting_t dir_rows[$];

  initial begin
    sighting_t s;
    logic [31:0] t;
    int k;
    err_cnt = 0;
    idle_cycles = 0;
    no_stall = 1'b0;
    done_flag = 1'b0;
    tbl_fill = 0;
    shw_all = 1'b0;
    shw_alpha = 9'(btt_pkg::AlphaReset);
    shw_timeout = btt_pkg::TimeoutReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // report on empty table after reset: one item, valid 0, last 1
    s = '{btt_pkg::CMD_REPORT, 1'b0, '0, '0, '0, '0, '0, '0};
    send_sighting(s);
    drain();

    // table of directed items
    dir_rows.push_back('{btt_pkg::CMD_OBSERVE, 1'b1, 32'hFFFF_FFFF, 32'h0, 8'h7F,
                         8'hFF, 8'hFF, 32'hFFFF_FFF0});
    dir_rows.push_back('{btt_pkg::CMD_OBSERVE, 1'b1, 32'h0, 32'hFFFF_FFFF, 8'h80,
                         8'h00, 8'h00, 32'h0});
    dir_rows.push_back('{btt_pkg::CMD_OBSERVE, 1'b1, 32'hFFFF_FFFF, 32'h0, 8'h80,
                         8'h5A, 8'hA5, 32'h10});
    // no payload, filtered mode: dropped
    dir_rows.push_back('{btt_pkg::CMD_OBSERVE, 1'b0, 32'h1234, 32'hAAAA_5555, 8'hF0,
                         8'h11, 8'h22, 32'h20});
    dir_rows.push_back('{btt_pkg::CMD_UNUSED, 1'b1, 32'h99, 32'h99, 8'h01, 8'h01,
                         8'h01, 32'h30});
    dir_rows.push_back('{btt_pkg::CMD_REPORT, 1'b0, '0, '0, '0, '0, '0, 32'h40});
    foreach (dir_rows[i]) send_sighting(dir_rows[i]);
    drain();

    // show-all mode, alpha over range and at extremes
    write_reg(btt_pkg::REG_SHOW_ALL, 32'd1);
    write_reg(btt_pkg::REG_ALPHA, 32'h1FF);
    s = '{btt_pkg::CMD_OBSERVE, 1'b0, 32'h0, 32'h5555_AAAA, 8'h05, 8'h7, 8'h7, 32'h50};
    send_sighting(s);
    s.rssi = 8'hFB;
    send_sighting(s);
    drain();
    write_reg(btt_pkg::REG_ALPHA, 32'd0);
    s.rssi = 8'h40;
    send_sighting(s);
    drain();
    write_reg(btt_pkg::REG_ALPHA, 32'd256);
    // fill the table past capacity, last ones dropped
    for (k = 0; k < 20; k++) begin
      s = '{btt_pkg::CMD_OBSERVE, 1'b1, 32'(100 + k), '0, 8'(k * 13), 8'(k), 8'(k),
            32'(k)};
      send_sighting(s);
    end
    s = '{btt_pkg::CMD_REPORT, 1'b0, '0, '0, '0, '0, '0, '0};
    send_sighting(s);
    drain();
    // expire with wrapped time and timeout extremes
    write_reg(btt_pkg::REG_TIMEOUT, 32'd0);
    s = '{btt_pkg::CMD_EXPIRE, 1'b0, '0, '0, '0, '0, '0, 32'h10};
    send_sighting(s);
    s = '{btt_pkg::CMD_REPORT, 1'b0, '0, '0, '0, '0, '0, '0};
    send_sighting(s);
    drain();
    write_reg(btt_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(btt_pkg::REG_ALPHA, 32'd77);

    // random part in phases with different settings
    t = $urandom();
    for (k = 0; k < RandItems; k++) begin
      if (k % 86 == 0) begin
        drain();
        write_reg(btt_pkg::REG_SHOW_ALL, 32'($urandom_range(1)));
        write_reg(btt_pkg::REG_ALPHA, (k == 172) ? 32'd256 : (k == 258) ? 32'd0 :
                  32'($urandom_range(511)));
        write_reg(btt_pkg::REG_TIMEOUT, (k == 344) ? 32'd0 : 32'($urandom_range(3000)));
        no_stall = (k == 86);
      end
      t = t + 32'($urandom_range(400));
      send_sighting(rand_sighting(t));
    end
    s = '{btt_pkg::CMD_REPORT, 1'b0, '0, '0, '0, '0, '0, t};
    send_sighting(s);
    drain();

    done_flag = 1'b1;
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
